FILE: design/adpcm_sa_pkg.sv
`default_nettype none
package adpcm_sa_pkg;

    // Field widths
    localparam int CMD_W     = 3;
    localparam int WORD_W    = 16;
    localparam int ADDR_W    = 32;
    localparam int FMT_W     = 16;
    localparam int COEF_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int SAMPLE_W  = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_ADDR = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD_YN1  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOAD_YN2  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LOAD_PRED = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_0     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_1     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_2     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_3     = 3'd6;

    // Sample formats
    localparam logic [FMT_W-1:0] FMT_ADPCM = 16'h0000;
    localparam logic [FMT_W-1:0] FMT_PCM16 = 16'h000A;

    // Predictor arithmetic
    localparam logic signed [33:0] PRED_ROUND = 34'sd1024;
    localparam logic signed [23:0] SAMPLE_MAX = 24'sd32767;
    localparam logic signed [23:0] SAMPLE_MIN = -24'sd32767;

endpackage
`default_nettype wire

FILE: design/adpcm_sa_cmd_if.sv
`default_nettype none
interface adpcm_sa_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [adpcm_sa_pkg::CMD_W-1:0]     cmd;
    logic [adpcm_sa_pkg::WORD_W-1:0]    word_in;
    logic [adpcm_sa_pkg::ADDR_W-1:0]    address_in;

    modport source (output valid, cmd, word_in, address_in, input ready);
    modport sink   (input valid, cmd, word_in, address_in, output ready);
endinterface
`default_nettype wire

FILE: design/adpcm_sa_res_if.sv
`default_nettype none
interface adpcm_sa_res_if;
    logic                               valid;
    logic                               ready;
    logic [adpcm_sa_pkg::SAMPLE_W-1:0]  sample;
    logic [adpcm_sa_pkg::ADDR_W-1:0]    next_address;
    logic                               loop_taken;
    logic                               unknown_format;

    modport source (output valid, sample, next_address, loop_taken, unknown_format,
                    input ready);
    modport sink   (input valid, sample, next_address, loop_taken, unknown_format,
                    output ready);
endinterface
`default_nettype wire

FILE: design/adpcm_sa_ram.sv
`default_nettype none
module adpcm_sa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; read data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: design/adpcm_sample_accelerator.sv
// A read is accepted into an idle engine and passes through S_NIB and S_SUM before its result
// is valid (S_HDR comes first at an ADPCM frame start, where the header byte is fetched); a 16-bit read
// passes through S_PCM_HI and S_PCM_LO. A write passes through S_WR_LO and a load completes in S_IDLE;
// the single read port of the byte store makes a read fetch its bytes one after another. The input
// and result registers let the next transaction enter while a result still waits.
// Reset clears position, history, predictor and the configuration registers; store contents stay unknown.
`default_nettype none
module adpcm_sample_accelerator #(
    parameter int STORE_BYTES = 65536   // power of two
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [adpcm_sa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [adpcm_sa_pkg::COEF_W-1:0]        i_cfg_data,
    adpcm_sa_cmd_if.sink                                i_cmd_if,
    adpcm_sa_res_if.source                              o_res_if
);

    localparam int SA_W = $clog2(STORE_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_NIB,
        S_SUM,
        S_PCM_HI,
        S_PCM_LO,
        S_WR_LO
    } t_state;

    // Configuration registers
    logic [adpcm_sa_pkg::FMT_W-1:0]     r_format;
    logic [adpcm_sa_pkg::ADDR_W-1:0]    r_loop_start;
    logic [adpcm_sa_pkg::ADDR_W-1:0]    r_loop_end;
    logic [adpcm_sa_pkg::COEF_W-1:0]    r_coef [4];

    // Input holding register
    logic                               r_in_full;
    logic [adpcm_sa_pkg::CMD_W-1:0]     r_in_cmd;
    logic [adpcm_sa_pkg::WORD_W-1:0]    r_in_word;
    logic [adpcm_sa_pkg::ADDR_W-1:0]    r_in_addr;

    // Engine state
    t_state                             r_state;
    logic [adpcm_sa_pkg::ADDR_W-1:0]    r_pos;
    logic [adpcm_sa_pkg::WORD_W-1:0]    r_yn1;
    logic [adpcm_sa_pkg::WORD_W-1:0]    r_yn2;
    logic [7:0]                         r_pred;
    logic [7:0]                         r_byte;
    logic signed [3:0]                  r_nib;
    logic signed [31:0]                 r_prod1;
    logic signed [31:0]                 r_prod2;

    // Result register
    logic                               r_out_vld;
    logic [adpcm_sa_pkg::SAMPLE_W-1:0]  r_out_sample;
    logic [adpcm_sa_pkg::ADDR_W-1:0]    r_out_addr;
    logic                               r_out_loop;
    logic                               r_out_unknown;

    logic                               w_take;
    logic                               w_out_free;
    logic                               w_is_adpcm;
    logic                               w_rd_en;
    logic [adpcm_sa_pkg::ADDR_W-1:0]    w_rd_addr;
    logic                               w_wr_en;
    logic [adpcm_sa_pkg::ADDR_W-1:0]    w_wr_addr;
    logic [7:0]                         w_wr_data;
    logic [7:0]                         w_rd_data;
    logic [adpcm_sa_pkg::ADDR_W-1:0]    w_pos1;
    logic [adpcm_sa_pkg::ADDR_W-1:0]    w_pos2;
    logic [adpcm_sa_pkg::COEF_W-1:0]    w_pack;
    logic [15:0]                        w_c1;
    logic [15:0]                        w_c2;
    logic [3:0]                         w_nib;
    logic signed [33:0]                 w_acc;
    logic signed [22:0]                 w_pred_sh;
    logic signed [23:0]                 w_nib_ext;
    logic signed [23:0]                 w_scaled;
    logic signed [23:0]                 w_val;
    logic [adpcm_sa_pkg::SAMPLE_W-1:0]  w_adpcm_sample;
    logic [adpcm_sa_pkg::ADDR_W-1:0]    w_next_pos;
    logic                               w_loop;
    logic [adpcm_sa_pkg::ADDR_W-1:0]    w_final_pos;

    assign w_take     = (r_state == S_IDLE) && r_in_full;
    assign w_out_free = !r_out_vld || o_res_if.ready;
    assign w_is_adpcm = (r_format == adpcm_sa_pkg::FMT_ADPCM);
    assign w_pos1     = r_pos + 32'd1;
    assign w_pos2     = r_pos + 32'd2;

    assign i_cmd_if.ready = !r_in_full || w_take;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format     <= '0;
            r_loop_start <= '0;
            r_loop_end   <= '0;
            r_coef[0]    <= '0;
            r_coef[1]    <= '0;
            r_coef[2]    <= '0;
            r_coef[3]    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                adpcm_sa_pkg::CFG_FORMAT:     r_format <= i_cfg_data[15:0];
                adpcm_sa_pkg::CFG_LOOP_START: r_loop_start <= i_cfg_data[31:0];
                adpcm_sa_pkg::CFG_LOOP_END:   r_loop_end <= i_cfg_data[31:0];
                adpcm_sa_pkg::CFG_COEF_0:     r_coef[0] <= i_cfg_data;
                adpcm_sa_pkg::CFG_COEF_1:     r_coef[1] <= i_cfg_data;
                adpcm_sa_pkg::CFG_COEF_2:     r_coef[2] <= i_cfg_data;
                adpcm_sa_pkg::CFG_COEF_3:     r_coef[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold one incoming transaction until the engine takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_full <= 1'b0;
        end else if (i_cmd_if.valid && i_cmd_if.ready) begin
            r_in_full <= 1'b1;
        end else if (w_take) begin
            r_in_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_if.valid && i_cmd_if.ready) begin
            r_in_cmd  <= i_cmd_if.cmd;
            r_in_word <= i_cmd_if.word_in;
            r_in_addr <= i_cmd_if.address_in;
        end
    end

    // Store port control
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_pos;
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = r_in_word[15:8];
        case (r_state)
            S_IDLE: begin
                if (r_in_full && r_in_cmd == adpcm_sa_pkg::CMD_READ) begin
                    w_rd_en = 1'b1;
                    if (w_is_adpcm) begin
                        if (r_pos[3:0] == 4'd0) begin
                            w_rd_addr = {1'b0, r_pos[31:4], 3'b000};
                        end else begin
                            w_rd_addr = {1'b0, r_pos[31:1]};
                        end
                    end
                end else if (r_in_full && r_in_cmd == adpcm_sa_pkg::CMD_WRITE) begin
                    w_wr_en = 1'b1;
                end
            end
            S_HDR: begin
                w_rd_en   = 1'b1;
                w_rd_addr = {1'b0, w_pos2[31:1]};
            end
            S_PCM_HI: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_pos1;
            end
            S_WR_LO: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_pos1;
                w_wr_data = r_byte;
            end
            default: ;
        endcase
    end

    adpcm_sa_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr[SA_W-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr[SA_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Coefficient pair picked by predictor bits 6:4
    assign w_pack = r_coef[r_pred[6:5]];
    assign w_c1   = r_pred[4] ? w_pack[47:32] : w_pack[15:0];
    assign w_c2   = r_pred[4] ? w_pack[63:48] : w_pack[31:16];
    assign w_nib  = r_pos[0] ? w_rd_data[3:0] : w_rd_data[7:4];

    // Rounded prediction, scaled nibble and clamp
    assign w_acc     = adpcm_sa_pkg::PRED_ROUND + 34'(r_prod1) + 34'(r_prod2);
    assign w_pred_sh = w_acc[33:11];
    assign w_nib_ext = 24'(r_nib);
    assign w_scaled  = w_nib_ext <<< r_pred[3:0];
    assign w_val     = 24'(w_pred_sh) + w_scaled;

    always_comb begin
        if (w_val > adpcm_sa_pkg::SAMPLE_MAX) begin
            w_adpcm_sample = adpcm_sa_pkg::SAMPLE_MAX[15:0];
        end else if (w_val < adpcm_sa_pkg::SAMPLE_MIN) begin
            w_adpcm_sample = adpcm_sa_pkg::SAMPLE_MIN[15:0];
        end else begin
            w_adpcm_sample = w_val[15:0];
        end
    end

    // Advance the position and take the loop when it reaches or passes the end address
    assign w_next_pos  = (r_state == S_SUM) ? w_pos1 : w_pos2;
    assign w_loop      = (w_next_pos >= r_loop_end);
    assign w_final_pos = w_loop ? r_loop_start : w_next_pos;

    // Sequencer, engine state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_yn1     <= '0;
            r_yn2     <= '0;
            r_pred    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_res_if.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        case (r_in_cmd)
                            adpcm_sa_pkg::CMD_READ: begin
                                if (!w_is_adpcm) begin
                                    r_state <= S_PCM_HI;
                                end else if (r_pos[3:0] == 4'd0) begin
                                    r_state <= S_HDR;
                                end else begin
                                    r_state <= S_NIB;
                                end
                            end
                            adpcm_sa_pkg::CMD_WRITE: begin
                                r_byte  <= r_in_word[7:0];
                                r_state <= S_WR_LO;
                            end
                            adpcm_sa_pkg::CMD_LOAD_ADDR: r_pos  <= r_in_addr;
                            adpcm_sa_pkg::CMD_LOAD_YN1:  r_yn1  <= r_in_word;
                            adpcm_sa_pkg::CMD_LOAD_YN2:  r_yn2  <= r_in_word;
                            adpcm_sa_pkg::CMD_LOAD_PRED: r_pred <= r_in_word[7:0];
                            default: ;
                        endcase
                    end
                end
                S_HDR: begin
                    r_pred  <= w_rd_data;
                    r_pos   <= w_pos2;
                    r_state <= S_NIB;
                end
                S_NIB: begin
                    r_nib   <= w_nib;
                    r_prod1 <= $signed(w_c1) * $signed(r_yn1);
                    r_prod2 <= $signed(w_c2) * $signed(r_yn2);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (w_out_free) begin
                        r_yn2         <= r_yn1;
                        r_yn1         <= w_adpcm_sample;
                        r_pos         <= w_final_pos;
                        r_out_vld     <= 1'b1;
                        r_out_sample  <= w_adpcm_sample;
                        r_out_addr    <= w_final_pos;
                        r_out_loop    <= w_loop;
                        r_out_unknown <= 1'b0;
                        r_state       <= S_IDLE;
                    end
                end
                S_PCM_HI: begin
                    r_byte  <= w_rd_data;
                    r_state <= S_PCM_LO;
                end
                S_PCM_LO: begin
                    if (w_out_free) begin
                        if (r_format == adpcm_sa_pkg::FMT_PCM16) begin
                            r_yn2 <= r_yn1;
                            r_yn1 <= {r_byte, w_rd_data};
                        end
                        r_pos         <= w_final_pos;
                        r_out_vld     <= 1'b1;
                        r_out_sample  <= {r_byte, w_rd_data};
                        r_out_addr    <= w_final_pos;
                        r_out_loop    <= w_loop;
                        r_out_unknown <= (r_format != adpcm_sa_pkg::FMT_PCM16);
                        r_state       <= S_IDLE;
                    end
                end
                S_WR_LO: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_if.valid          = r_out_vld;
    assign o_res_if.sample         = r_out_sample;
    assign o_res_if.next_address   = r_out_addr;
    assign o_res_if.loop_taken     = r_out_loop;
    assign o_res_if.unknown_format = r_out_unknown;

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import adpcm_sa_pkg::*;

    localparam int STORE_BYTES    = 65536;
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 110;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic [ADDR_W-1:0]   next_address;
        logic                loop_taken;
        logic                unknown_format;
    } sample_result_t;

    typedef struct {
        logic [FMT_W-1:0]  fmt;
        logic [ADDR_W-1:0] loop_start;
        logic [ADDR_W-1:0] loop_end;
        logic [COEF_W-1:0] coef [4];
        logic [ADDR_W-1:0] base;
        bit                hold;
    } phase_cfg_t;

    // Tracks the accelerator state and the samples it owes
    class sample_predictor;
        logic [7:0]        mem [STORE_BYTES];
        bit                written [STORE_BYTES];
        logic [ADDR_W-1:0] position;
        logic [15:0]       yn1;
        logic [15:0]       yn2;
        logic [7:0]        pred_scale;
        logic [FMT_W-1:0]  fmt;
        logic [ADDR_W-1:0] loop_start;
        logic [ADDR_W-1:0] loop_end;
        logic [COEF_W-1:0] coef [4];
        sample_result_t    expected_samples [$];
        int                mismatches;

        function new();
            position   = '0;
            yn1        = '0;
            yn2        = '0;
            pred_scale = '0;
            fmt        = FMT_ADPCM;
            loop_start = '0;
            loop_end   = '0;
            foreach (coef[k]) coef[k] = '0;
            foreach (written[k]) written[k] = 1'b0;
            mismatches = 0;
        endfunction

        function logic [7:0] byte_at(logic [ADDR_W-1:0] a);
            return mem[a % STORE_BYTES];
        endfunction

        function void put_byte(logic [ADDR_W-1:0] a, logic [7:0] v);
            mem[a % STORE_BYTES]     = v;
            written[a % STORE_BYTES] = 1'b1;
        endfunction

        function bit is_written(logic [ADDR_W-1:0] a);
            return written[a % STORE_BYTES];
        endfunction

        // A read may only touch bytes that were written before
        function bit read_safe();
            logic [ADDR_W-1:0] p;
            p = position;
            if (fmt == FMT_ADPCM) begin
                if (p[3:0] == 4'd0) begin
                    if (!is_written(p >> 1)) return 1'b0;
                    p = p + 32'd2;
                end
                return is_written(p >> 1);
            end
            return is_written(p) && is_written(p + 32'd1);
        endfunction

        function longint coef_of(int pair, int tap);
            int          slot;
            logic [15:0] raw;
            slot = pair * 2 + tap;
            raw  = coef[slot / 4][16 * (slot % 4) +: 16];
            return longint'($signed(raw));
        endfunction

        function void push_history(logic [15:0] v);
            yn2 = yn1;
            yn1 = v;
        endfunction

        // One ADPCM nibble: load the frame header on a frame start, then predict
        function logic [15:0] decode_nibble(inout logic [ADDR_W-1:0] p);
            longint     scale;
            longint     nib;
            longint     c1;
            longint     c2;
            longint     acc;
            longint     val;
            logic [7:0] b;
            if (p[3:0] == 4'd0) begin
                pred_scale = byte_at(p >> 1);
                p = p + 32'd2;
            end
            scale = longint'(1) << pred_scale[3:0];
            c1    = coef_of(int'(pred_scale[6:4]), 0);
            c2    = coef_of(int'(pred_scale[6:4]), 1);
            b     = byte_at(p >> 1);
            nib   = p[0] ? longint'(b[3:0]) : longint'(b[7:4]);
            if (nib >= 8) nib = nib - 16;
            acc = longint'(PRED_ROUND) + c1 * longint'($signed(yn1))
                + c2 * longint'($signed(yn2));
            acc = acc >>> 11;
            val = scale * nib + acc;
            if (val > longint'(SAMPLE_MAX)) val = longint'(SAMPLE_MAX);
            else if (val < longint'(SAMPLE_MIN)) val = longint'(SAMPLE_MIN);
            push_history(val[15:0]);
            p = p + 32'd1;
            return val[15:0];
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
            case (idx)
                CFG_FORMAT:     fmt        = data[FMT_W-1:0];
                CFG_LOOP_START: loop_start = data[ADDR_W-1:0];
                CFG_LOOP_END:   loop_end   = data[ADDR_W-1:0];
                CFG_COEF_0:     coef[0]    = data;
                CFG_COEF_1:     coef[1]    = data;
                CFG_COEF_2:     coef[2]    = data;
                CFG_COEF_3:     coef[3]    = data;
                default: ;
            endcase
        endfunction

        // Apply one accepted command; a read queues its sample
        function void take_command(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] word,
                                   logic [ADDR_W-1:0] addr);
            logic [ADDR_W-1:0] p;
            sample_result_t    r;
            case (cmd)
                CMD_READ: begin
                    p = position;
                    r.unknown_format = 1'b0;
                    r.loop_taken     = 1'b0;
                    if (fmt == FMT_ADPCM) begin
                        r.sample = decode_nibble(p);
                    end else begin
                        r.sample = {byte_at(p), byte_at(p + 32'd1)};
                        if (fmt == FMT_PCM16) push_history(r.sample);
                        else r.unknown_format = 1'b1;
                        p = p + 32'd2;
                    end
                    if (p >= loop_end) begin
                        p = loop_start;
                        r.loop_taken = 1'b1;
                    end
                    position       = p;
                    r.next_address = p;
                    expected_samples.push_back(r);
                end
                CMD_WRITE: begin
                    put_byte(position, word[15:8]);
                    put_byte(position + 32'd1, word[7:0]);
                end
                CMD_LOAD_ADDR: position   = addr;
                CMD_LOAD_YN1:  yn1        = word;
                CMD_LOAD_YN2:  yn2        = word;
                CMD_LOAD_PRED: pred_scale = word[7:0];
                default: ;
            endcase
        endfunction

        function void compare_sample(sample_result_t got);
            sample_result_t exp;
            if (expected_samples.size() == 0) begin
                $error("sample result with no expected sample: sample %h", got.sample);
                mismatches++;
                return;
            end
            exp = expected_samples.pop_front();
            if (exp.sample !== got.sample) begin
                $error("sample mismatch: expected %h, actual %h", exp.sample, got.sample);
                mismatches++;
            end
            if (exp.next_address !== got.next_address) begin
                $error("next_address mismatch: expected %h, actual %h",
                       exp.next_address, got.next_address);
                mismatches++;
            end
            if (exp.loop_taken !== got.loop_taken) begin
                $error("loop_taken mismatch: expected %b, actual %b",
                       exp.loop_taken, got.loop_taken);
                mismatches++;
            end
            if (exp.unknown_format !== got.unknown_format) begin
                $error("unknown_format mismatch: expected %b, actual %b",
                       exp.unknown_format, got.unknown_format);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COEF_W-1:0]    i_cfg_data;

    adpcm_sa_cmd_if cmd_if ();
    adpcm_sa_res_if res_if ();

    adpcm_sample_accelerator #(.STORE_BYTES(STORE_BYTES)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd_if   (cmd_if),
        .o_res_if   (res_if)
    );

    sample_predictor pred = new();
    bit              steady = 1'b0;
    bit              hold_req = 1'b0;
    int              quiet_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL adpcm_sample_accelerator");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        int             stall;
        sample_result_t got;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = steady ? 0 : $urandom_range(0, 12);
                if (stall > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            got.sample         = res_if.sample;
            got.next_address   = res_if.next_address;
            got.loop_taken     = res_if.loop_taken;
            got.unknown_format = res_if.unknown_format;
            pred.compare_sample(got);
        end
    end

    // Position whose bytes lie in the preloaded windows at both ends of the store
    function automatic logic [ADDR_W-1:0] safe_position(logic [FMT_W-1:0] fmt,
                                                        logic [ADDR_W-1:0] base);
        logic [16:0] nib_off;
        logic [15:0] byte_off;
        if (fmt == FMT_ADPCM) begin
            nib_off = $urandom_range(0, 1) ? 17'($urandom_range(0, 511))
                                           : 17'($urandom_range(17'h1FE00, 17'h1FFFF));
            if ($urandom_range(0, 2) == 0) nib_off[3:0] = 4'd0;
            return {base[31:17], nib_off};
        end
        byte_off = $urandom_range(0, 1) ? 16'($urandom_range(0, 254))
                                        : 16'($urandom_range(16'hFF00, 16'hFFFF));
        return {base[31:16], byte_off};
    endfunction

    function automatic logic [COEF_W-1:0] coef_pack(int mode);
        logic [COEF_W-1:0] pack;
        for (int k = 0; k < 4; k++) begin
            case (mode)
                0:       pack[16*k +: 16] = 16'($urandom_range(0, 4095)) - 16'd2048;
                1:       pack[16*k +: 16] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                default: pack[16*k +: 16] = 16'($urandom);
            endcase
        end
        return pack;
    endfunction

    // One command transaction; the predictor sees it once accepted
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] word,
                                logic [ADDR_W-1:0] addr);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.cmd        <= cmd;
        cmd_if.word_in    <= word;
        cmd_if.address_in <= addr;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        pred.take_command(cmd, word, addr);
    endtask

    // Move the position first when a read would touch unwritten bytes
    task automatic issue(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] word,
                         logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] base);
        if (cmd == CMD_READ && !pred.read_safe())
            send_command(CMD_LOAD_ADDR, 16'($urandom), safe_position(pred.fmt, base));
        send_command(cmd, word, addr);
    endtask

    // Drain: drop valid, wait for all samples, let trailing work settle
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (pred.expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        pred.set_register(idx, data);
    endtask

    task automatic program_phase(phase_cfg_t pc);
        write_register(CFG_FORMAT, COEF_W'(pc.fmt));
        write_register(CFG_LOOP_START, COEF_W'(pc.loop_start));
        write_register(CFG_LOOP_END, COEF_W'(pc.loop_end));
        write_register(CFG_COEF_0, pc.coef[0]);
        write_register(CFG_COEF_1, pc.coef[1]);
        write_register(CFG_COEF_2, pc.coef[2]);
        write_register(CFG_COEF_3, pc.coef[3]);
        i_cfg_we <= 1'b0;
    endtask

    function automatic phase_cfg_t make_phase(int k);
        phase_cfg_t pc;
        int         mode;
        pc.hold = 1'b0;
        pc.base = 32'($urandom);
        mode    = 2;
        case (k)
            0: begin
                pc.fmt = FMT_ADPCM; pc.base = '0; mode = 0;
            end
            1: begin
                pc.fmt = FMT_ADPCM; pc.base = '0; mode = 0;
            end
            2: begin
                pc.fmt = FMT_ADPCM; pc.base = '1; mode = 1;
            end
            3: begin
                pc.fmt = FMT_PCM16; pc.hold = 1'b1;
            end
            4: pc.fmt = FMT_ADPCM;
            5: pc.fmt = 16'hFFFF;
            6: begin
                pc.fmt = 16'($urandom_range(1, 16'hFFFF));
                if (pc.fmt == FMT_PCM16) pc.fmt = FMT_PCM16 + 16'd1;
            end
            7: pc.fmt = FMT_PCM16;
            default: begin
                pc.fmt = FMT_ADPCM; mode = 0;
            end
        endcase
        for (int c = 0; c < 4; c++) pc.coef[c] = coef_pack(mode);
        pc.loop_start = safe_position(pc.fmt, pc.base);
        pc.loop_end   = pc.loop_start + 32'($urandom_range(4, 600));
        // Loop extremes
        case (k)
            0: begin pc.loop_start = '0; pc.loop_end = '0; end
            2: begin pc.loop_start = '1; pc.loop_end = '1; end
            5: begin pc.loop_start = '1; pc.loop_end = '0; end
            7: begin pc.loop_start = '0; pc.loop_end = '1; end
            default: ;
        endcase
        return pc;
    endfunction

    task automatic random_item(logic [ADDR_W-1:0] base);
        int                r;
        logic [WORD_W-1:0] word;
        logic [ADDR_W-1:0] addr;
        r    = $urandom_range(0, 99);
        word = 16'($urandom);
        addr = 32'($urandom);
        if (r < 55) begin
            issue(CMD_READ, word, addr, base);
        end else if (r < 65) begin
            issue(CMD_WRITE, word, addr, base);
        end else if (r < 75) begin
            if ($urandom_range(0, 9) < 7) addr = safe_position(pred.fmt, base);
            issue(CMD_LOAD_ADDR, word, addr, base);
        end else if (r < 87) begin
            if ($urandom_range(0, 3) == 0) word = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            issue((r < 81) ? CMD_LOAD_YN1 : CMD_LOAD_YN2, word, addr, base);
        end else if (r < 95) begin
            issue(CMD_LOAD_PRED, word, addr, base);
        end else begin
            issue(CMD_LOAD_PRED + CMD_W'($urandom_range(1, 2)), word, addr, base);
        end
    endtask

    initial begin
        phase_cfg_t pc;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_FORMAT;
        i_cfg_data        <= '0;
        cmd_if.valid      <= 1'b0;
        cmd_if.cmd        <= CMD_READ;
        cmd_if.word_in    <= '0;
        cmd_if.address_in <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Preload both ends of the store so reads never see unwritten bytes
        for (int b = 0; b < 128; b++) begin
            send_command(CMD_LOAD_ADDR, 16'($urandom),
                         {16'($urandom), 16'(2 * b)});
            send_command(CMD_WRITE, 16'($urandom), 32'($urandom));
            send_command(CMD_LOAD_ADDR, 16'($urandom),
                         {16'($urandom), 16'hFF00 + 16'(2 * b)});
            send_command(CMD_WRITE, 16'($urandom), 32'($urandom));
        end
        drain();

        // Directed: history and predictor extremes, frame starts, wrap of position
        pc = make_phase(1);
        pc.loop_start = '0;
        pc.loop_end   = '1;
        program_phase(pc);
        issue(CMD_LOAD_YN1, 16'h7FFF, '0, '0);
        issue(CMD_LOAD_YN2, 16'h8000, '0, '0);
        issue(CMD_LOAD_PRED, 16'hFFFF, '1, '0);
        issue(CMD_LOAD_ADDR, '0, 32'd1, '0);
        issue(CMD_READ, '1, '1, '0);
        issue(CMD_READ, '0, '0, '0);
        issue(CMD_LOAD_ADDR, '1, 32'hFFFF_FFF0, '0);
        issue(CMD_READ, '0, '0, '0);
        issue(CMD_READ, '0, '0, '0);
        issue(CMD_LOAD_ADDR, '0, 32'hFFFF_FFFF, '0);
        issue(CMD_READ, '0, '0, '0);
        issue(CMD_READ, '0, '0, '0);
        issue(CMD_LOAD_PRED + CMD_W'(1), '1, '1, '0);
        issue(CMD_LOAD_PRED + CMD_W'(2), '0, '0, '0);
        issue(CMD_LOAD_PRED, 16'hFF00, '0, '0);
        issue(CMD_LOAD_YN1, 16'h8000, '0, '0);
        issue(CMD_LOAD_YN2, 16'h7FFF, '0, '0);
        issue(CMD_LOAD_ADDR, '0, 32'd3, '0);
        issue(CMD_READ, '0, '0, '0);
        issue(CMD_WRITE, 16'hFFFF, '0, '0);
        issue(CMD_LOAD_ADDR, '0, 32'hFFFF_FFFF, '0);
        issue(CMD_WRITE, 16'h8001, '0, '0);
        issue(CMD_LOAD_ADDR, '0, 32'hFFFF_FFFE, '0);
        issue(CMD_READ, '0, '0, '0);
        issue(CMD_READ, '0, '0, '0);
        drain();

        // Random phases, each with its own register setting
        for (int k = 0; k < PHASES; k++) begin
            pc = make_phase(k);
            program_phase(pc);
            if (pc.hold) hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
                random_item(pc.base);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pred.mismatches == 0 && pred.expected_samples.size() == 0) begin
            $display("PASS adpcm_sample_accelerator");
        end else begin
            $display("FAIL adpcm_sample_accelerator");
        end
        $finish;
    end

endmodule
`default_nettype wire
